### hw/rtl/bfh_pkg.sv
// shared types and constants of the byte frequency histogram
`default_nettype none

package bfh_pkg;

    localparam int NUM_BINS        = 256;
    localparam int BIN_W           = 8;
    localparam int GROUP_SIZE      = 16;
    localparam int NUM_GROUPS      = NUM_BINS / GROUP_SIZE;
    localparam int GRP_W           = 4;
    localparam int SUB_W           = 4;
    localparam int DC_W            = 9;
    localparam int OCC_W           = 32;
    localparam int OP_W            = 2;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = 1;

    localparam logic [OP_W-1:0] OP_COUNT  = 2'd0;
    localparam logic [OP_W-1:0] OP_FINISH = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [BIN_W-1:0] byte_value;
    } cmd_t;

    typedef struct packed {
        logic             done;
        logic [DC_W-1:0]  distinct_count;
        logic [BIN_W-1:0] symbol;
        logic [OCC_W-1:0] occurrences;
        logic             is_last;
        logic             is_empty;
    } result_t;

endpackage

`default_nettype wire

### hw/rtl/bfh_ram.sv
// generic single write, single read ram with registered read data
`default_nettype none

module bfh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hw/rtl/bfh_front.sv
// front end: item acceptance, operation decode and command queue
`default_nettype none

module bfh_front import bfh_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [OP_W-1:0]  operation,
    input  wire logic [BIN_W-1:0] byte_value,
    output logic                  busy,
    output logic                  q_valid,
    output cmd_t                  q_cmd,
    input  wire logic             q_pop
);

    cmd_t              q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   fill_reg, fill_next;
    logic              accept;
    logic              push;
    logic              pop;

    assign busy    = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign accept  = start && !busy;
    assign q_valid = (fill_reg != '0);
    assign q_cmd   = q_mem_reg[rd_ptr_reg];
    assign pop     = q_pop && q_valid;

    // unused operation code is dropped here
    always_comb
    begin
        push = 1'b0;
        if (accept)
        begin
            unique case (operation)
                OP_COUNT, OP_FINISH, OP_READ: push = 1'b1;
                default:                      push = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + (QPTR_W+1)'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= '{operation: operation, byte_value: byte_value};
        end
    end

endmodule

`default_nettype wire

### hw/rtl/bfh_back.sv
// back end: bin update, lowest bin search and result register
`default_nettype none

module bfh_back import bfh_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_valid,
    input  wire cmd_t q_cmd,
    output logic      q_pop,
    output result_t   res
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_CNT      = 3'd1;
    localparam logic [2:0] S_RD_GROUP = 3'd2;
    localparam logic [2:0] S_RD_BIN   = 3'd3;
    localparam logic [2:0] S_RD_DATA  = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [NUM_BINS-1:0]    live_reg, live_next;
    logic [DC_W-1:0]        tally_reg, tally_next;
    logic [BIN_W-1:0]       addr_reg, addr_next;
    logic [GRP_W-1:0]       grp_reg, grp_next;
    result_t                res_reg, res_next;

    logic                   ram_wr_en;
    logic                   ram_rd_en;
    logic [BIN_W-1:0]       ram_rd_addr;
    logic [COUNT_WIDTH-1:0] ram_rd_data;
    logic [COUNT_WIDTH-1:0] cur_count;
    logic [COUNT_WIDTH-1:0] inc_count;
    logic [OCC_W-1:0]       occ_sat;
    logic [NUM_GROUPS-1:0]  group_any;

    function automatic logic [SUB_W-1:0] lowest_set(input logic [GROUP_SIZE-1:0] v);
        logic [SUB_W-1:0] idx;
        idx = '0;
        for (int i = GROUP_SIZE - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = SUB_W'(i);
            end
        end
        return idx;
    endfunction

    bfh_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_BINS)
    ) u_bins (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (addr_reg),
        .wr_data (inc_count),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // a bin without its live bit reads as zero
    assign cur_count = live_reg[addr_reg] ? ram_rd_data : '0;
    assign inc_count = cur_count + COUNT_WIDTH'(1);

    generate
        if (COUNT_WIDTH > OCC_W)
        begin : g_sat
            assign occ_sat = (|ram_rd_data[COUNT_WIDTH-1:OCC_W]) ? '1 : ram_rd_data[OCC_W-1:0];
        end
        else
        begin : g_ext
            assign occ_sat = OCC_W'(ram_rd_data);
        end
    endgenerate

    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            group_any[g] = |live_reg[g*GROUP_SIZE +: GROUP_SIZE];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        live_next   = live_reg;
        tally_next  = tally_reg;
        addr_next   = addr_reg;
        grp_next    = grp_reg;
        res_next    = '0;
        q_pop       = 1'b0;
        ram_wr_en   = 1'b0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = q_cmd.byte_value;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_cmd.operation)
                        OP_COUNT:
                        begin
                            ram_rd_en  = 1'b1;
                            addr_next  = q_cmd.byte_value;
                            state_next = S_CNT;
                        end
                        OP_FINISH:
                        begin
                            res_next.done           = 1'b1;
                            res_next.distinct_count = tally_reg;
                        end
                        OP_READ:
                        begin
                            state_next = S_RD_GROUP;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CNT:
            begin
                if (!live_reg[addr_reg])
                begin
                    live_next[addr_reg] = 1'b1;
                    tally_next          = tally_reg + DC_W'(1);
                end
                // saturated bin stays at its maximum
                ram_wr_en  = (cur_count != '1);
                state_next = S_IDLE;
            end
            S_RD_GROUP:
            begin
                if (|group_any)
                begin
                    grp_next   = lowest_set(group_any);
                    state_next = S_RD_BIN;
                end
                else
                begin
                    res_next.done     = 1'b1;
                    res_next.is_empty = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            S_RD_BIN:
            begin
                ram_rd_addr = {grp_reg, lowest_set(live_reg[grp_reg*GROUP_SIZE +: GROUP_SIZE])};
                ram_rd_en   = 1'b1;
                addr_next   = ram_rd_addr;
                state_next  = S_RD_DATA;
            end
            S_RD_DATA:
            begin
                res_next.done           = 1'b1;
                res_next.distinct_count = tally_reg;
                res_next.symbol         = addr_reg;
                res_next.occurrences    = occ_sat;
                res_next.is_last        = (tally_reg == DC_W'(1));
                live_next[addr_reg]     = 1'b0;
                tally_next              = tally_reg - DC_W'(1);
                state_next              = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            live_reg  <= '0;
            tally_reg <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            live_reg  <= live_next;
            tally_reg <= tally_next;
            res_reg   <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        grp_reg  <= grp_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

### hw/rtl/byte_frequency_histogram.sv
// top level of the byte frequency histogram
`default_nettype none

// byte frequency histogram, 256 bins that start cleared after reset (a live bit
// per bin, so there is no clearing pass). an item is taken when start is high and
// busy is low; busy rises only while the two-entry command queue is full. each
// result shows for exactly one cycle with done high and must be taken then; the
// receiver cannot hold results off. the back end handles one queued item at a
// time, starting the cycle after the item is taken at the earliest: a count reads
// the bin ram, then writes the incremented value; a finish gives the tally; a read
// runs a group search over the live bits, a bin search inside the group, a bin ram
// read and the result, stopping after the group search when the store is empty.
// results leave in item order, the cycle after the back end finishes with the
// item. operation code 3 is dropped at the front and gives no result. occurrences
// saturates at all ones of 32 bits when the bin counters are wider.

module byte_frequency_histogram import bfh_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [OP_W-1:0]  operation,
    input  wire logic [BIN_W-1:0] byte_value,
    output logic                  done,
    output logic [DC_W-1:0]       distinct_count,
    output logic [BIN_W-1:0]      symbol,
    output logic [OCC_W-1:0]      occurrences,
    output logic                  is_last,
    output logic                  is_empty
);

    // command queue handshake between front and back
    logic    q_valid;
    logic    q_pop;
    cmd_t    q_cmd;
    result_t res;

    // front: takes items, drops the unused code, queues the rest
    bfh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .operation  (operation),
        .byte_value (byte_value),
        .busy       (busy),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .q_pop      (q_pop)
    );

    // back: bin store, distinct tally and readout sequencer
    bfh_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop),
        .res     (res)
    );

    // result fields straight from the back end's output register
    assign done           = res.done;
    assign distinct_count = res.distinct_count;
    assign symbol         = res.symbol;
    assign occurrences    = res.occurrences;
    assign is_last        = res.is_last;
    assign is_empty       = res.is_empty;

endmodule

`default_nettype wire
